// ===== src/crq_pkg.sv =====
// crq_pkg: shared constants and types for the character ring queue
// request and status codes, field widths, step unit result struct
// no dependencies
`timescale 1ns / 1ps

package crq_pkg;

  localparam int DEF_DEPTH   = 1024;
  localparam int QSIZE_RESET = 1024;
  localparam int CNT_W       = 11;
  localparam int REQ_W       = 3;
  localparam int STAT_W      = 2;

  localparam logic [REQ_W-1:0] REQ_PUT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GET   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_UNPUT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SCAN  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic hit;
    logic at_end;
    logic wrap;
  } step_res_t;

endpackage

// ===== src/char_ring_queue_with_quote_bits_unit.sv =====
// char_ring_queue_with_quote_bits_unit: byte ring queue with a quote bit per entry
// top level: sequencer, indices and counts; uses crq_ram, crq_step_unit, crq_pkg
//
// usage
//   a request is taken when start is high and busy is low; req_type selects
//   put, get, unput, flush or scan, the other inputs carry its operands
//   each request gives one result on status, byte_out, quote_out, run_count
//   and fill_level, marked by done for exactly one cycle; the receiver must
//   take it then, there is no way to hold it off
//   put, get, unput, flush and unknown codes: done two cycles after the
//   request is taken (one cycle for the registered store read, one to update)
//   scan: done after 2 + n cycles, n the entries counted, as the shared step
//   unit walks one store entry per cycle through the read port
//   a new request can be taken in the cycle done is high
//   cfg_we writes queue_size (0 reads as 1, above DEPTH saturates) and
//   empties the queue; write only while busy is low
//   reset empties the queue and sets queue_size to 1024 or DEPTH if smaller;
//   store contents are not cleared, entries are read only after being written
`timescale 1ns / 1ps

module char_ring_queue_with_quote_bits_unit #(
  parameter int DEPTH = crq_pkg::DEF_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [crq_pkg::REQ_W-1:0]    req_type,
  input  logic [7:0]                   data_byte,
  input  logic                         quote_in,
  input  logic [crq_pkg::CNT_W-1:0]    flush_count,
  input  logic [7:0]                   match_mask,
  input  logic                         match_quote,
  input  logic                         cfg_we,
  input  logic [crq_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                         done,
  output logic [crq_pkg::STAT_W-1:0]   status,
  output logic [7:0]                   byte_out,
  output logic                         quote_out,
  output logic [crq_pkg::CNT_W-1:0]    run_count,
  output logic [crq_pkg::CNT_W-1:0]    fill_level
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > crq_pkg::CNT_W) ? CW : crq_pkg::CNT_W) + 1;
  localparam int QRST = (crq_pkg::QSIZE_RESET > DEPTH) ? DEPTH : crq_pkg::QSIZE_RESET;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_t;

  state_t state;

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [CW-1:0] qsize;

  logic [crq_pkg::REQ_W-1:0] req;
  logic [7:0]                req_byte;
  logic                      req_quote;
  logic [crq_pkg::CNT_W-1:0] req_fcount;
  logic [7:0]                req_mask;
  logic                      req_mquote;

  logic [CW-1:0] scan_idx;
  logic [CW-1:0] scan_left;
  logic [CW-1:0] scan_run;

  logic          accept;
  logic [AW-1:0] tail_dec;
  logic [AW-1:0] rd_addr;
  logic [8:0]    rd_data;
  logic          wr_en;
  logic [CW-1:0] step_idx;
  logic [CW-1:0] step_inc;
  crq_pkg::step_res_t step_res;
  logic          is_full;
  logic          is_empty;

  logic [SW-1:0] flush_sum;
  logic [SW-1:0] flush_head;
  logic          flush_all;
  logic [SW-1:0] cfg_ext;
  logic [CW-1:0] cfg_qsize;

  // tail advance with wrap at the queue size
  function automatic logic [AW-1:0] step_unused_wrap(input logic [AW-1:0] idx);
    logic [CW-1:0] nxt;
    nxt = CW'(idx) + CW'(1);
    return (nxt >= qsize) ? AW'(0) : nxt[AW-1:0];
  endfunction

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count >= qsize);
  assign is_empty = (count == CW'(0));
  assign tail_dec = (tail == AW'(0)) ? AW'(qsize - CW'(1)) : tail - AW'(1);
  assign wr_en    = (state == S_EXEC) && (req == crq_pkg::REQ_PUT) && !is_full;
  assign step_idx = (state == S_SCAN) ? scan_idx : CW'(head);

  assign flush_sum  = SW'(head) + SW'(req_fcount);
  assign flush_head = (flush_sum >= SW'(qsize)) ? flush_sum - SW'(qsize) : flush_sum;
  assign flush_all  = (SW'(req_fcount) >= SW'(count));

  assign cfg_ext   = SW'(cfg_wdata);
  assign cfg_qsize = (cfg_ext == SW'(0)) ? CW'(1) :
                     (cfg_ext > SW'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_ext);

  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = step_inc[AW-1:0];
    end else if (req_type == crq_pkg::REQ_UNPUT) begin
      rd_addr = tail_dec;
    end else begin
      rd_addr = head;
    end
  end

  crq_ram #(
    .WIDTH(9),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(tail),
    .wdata({req_quote, req_byte}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  crq_step_unit #(
    .CW(CW)
  ) u_step (
    .idx        (step_idx),
    .qsize      (qsize),
    .entry_byte (rd_data[7:0]),
    .entry_quote(rd_data[8]),
    .mask       (req_mask),
    .mquote     (req_mquote),
    .inc        (step_inc),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      qsize <= CW'(QRST);
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        qsize <= cfg_qsize;
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req        <= req_type;
            req_byte   <= data_byte;
            req_quote  <= quote_in;
            req_fcount <= flush_count;
            req_mask   <= match_mask;
            req_mquote <= match_quote;
            scan_idx   <= CW'(head);
            scan_left  <= count;
            scan_run   <= '0;
            state      <= (req_type == crq_pkg::REQ_SCAN) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          done      <= 1'b1;
          status    <= crq_pkg::ST_OK;
          byte_out  <= 8'd0;
          quote_out <= 1'b0;
          run_count <= '0;
          fill_level <= crq_pkg::CNT_W'(count);
          state     <= S_IDLE;
          unique case (req)
            crq_pkg::REQ_PUT: begin
              if (is_full) begin
                status <= crq_pkg::ST_FULL;
              end else begin
                tail       <= step_unused_wrap(tail);
                count      <= count + CW'(1);
                fill_level <= crq_pkg::CNT_W'(count + CW'(1));
              end
            end
            crq_pkg::REQ_GET, crq_pkg::REQ_UNPUT: begin
              if (is_empty) begin
                status <= crq_pkg::ST_EMPTY;
              end else begin
                byte_out   <= rd_data[7:0];
                quote_out  <= rd_data[8];
                count      <= count - CW'(1);
                fill_level <= crq_pkg::CNT_W'(count - CW'(1));
                if (count == CW'(1)) begin
                  head <= '0;
                  tail <= '0;
                end else if (req == crq_pkg::REQ_GET) begin
                  head <= step_res.wrap ? AW'(0) : step_inc[AW-1:0];
                end else begin
                  tail <= tail_dec;
                end
              end
            end
            crq_pkg::REQ_FLUSH: begin
              if (flush_all) begin
                head       <= '0;
                tail       <= '0;
                count      <= '0;
                fill_level <= '0;
              end else begin
                head       <= AW'(flush_head);
                count      <= count - CW'(req_fcount);
                fill_level <= crq_pkg::CNT_W'(count - CW'(req_fcount));
              end
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (scan_left == CW'(0) || step_res.at_end || step_res.hit) begin
            done       <= 1'b1;
            status     <= crq_pkg::ST_OK;
            byte_out   <= 8'd0;
            quote_out  <= 1'b0;
            run_count  <= crq_pkg::CNT_W'(scan_run);
            fill_level <= crq_pkg::CNT_W'(count);
            state      <= S_IDLE;
          end else begin
            scan_idx  <= step_inc;
            scan_left <= scan_left - CW'(1);
            scan_run  <= scan_run + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= qsize)
    else $error("entry count above queue size");

  a_empty_home: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(0)) |-> (head == AW'(0) && tail == AW'(0)))
    else $error("empty queue with indices away from zero");

  a_head_range: assert property (@(posedge clk) disable iff (rst) CW'(head) < qsize)
    else $error("head index beyond queue size");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a request in progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_run + scan_left == count))
    else $error("scan run and remaining entries out of step");

endmodule

// ===== src/crq_ram.sv =====
// crq_ram: generic single write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module crq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/crq_step_unit.sv =====
// crq_step_unit: shared index step and entry match unit
// increments an index against the queue size and tests a stored entry
// depends on crq_pkg
`timescale 1ns / 1ps

module crq_step_unit #(
  parameter int CW = 11
) (
  input  logic [CW-1:0]      idx,
  input  logic [CW-1:0]      qsize,
  input  logic [7:0]         entry_byte,
  input  logic               entry_quote,
  input  logic [7:0]         mask,
  input  logic               mquote,
  output logic [CW-1:0]      inc,
  output crq_pkg::step_res_t res
);

  assign inc        = idx + CW'(1);
  assign res.wrap   = (inc >= qsize);
  assign res.at_end = (idx >= qsize);
  assign res.hit    = ((entry_byte & mask) != 8'd0) || (mquote && entry_quote);

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for char_ring_queue_with_quote_bits_unit
// drives put, get, unput, flush, scan and unknown-code requests, predicts every result in step
// depends on crq_pkg and the char_ring_queue_with_quote_bits_unit rtl
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 20_000_000;
  localparam logic [crq_pkg::REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [crq_pkg::REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [crq_pkg::REQ_W-1:0] req;
    logic [7:0]                data;
    logic                      quote;
    logic [crq_pkg::CNT_W-1:0] fcnt;
    logic [7:0]                mask;
    logic                      mquote;
  } queue_req_t;

  typedef struct packed {
    logic [crq_pkg::STAT_W-1:0] status;
    logic [7:0]                 byte_val;
    logic                       quote_val;
    logic [crq_pkg::CNT_W-1:0]  run;
    logic [crq_pkg::CNT_W-1:0]  fill;
  } queue_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [crq_pkg::REQ_W-1:0]  req_type = '0;
  logic [7:0]                 data_byte = '0;
  logic                       quote_in = 1'b0;
  logic [crq_pkg::CNT_W-1:0]  flush_count = '0;
  logic [7:0]                 match_mask = '0;
  logic                       match_quote = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [crq_pkg::CNT_W-1:0]  cfg_wdata = '0;
  logic                       done;
  logic [crq_pkg::STAT_W-1:0] status;
  logic [7:0]                 byte_out;
  logic                       quote_out;
  logic [crq_pkg::CNT_W-1:0]  run_count;
  logic [crq_pkg::CNT_W-1:0]  fill_level;

  queue_req_t    pending_q[$];
  queue_result_t expected_results[$];
  logic          taken = 1'b0;
  int            idle_pct = 0;
  int            errors = 0;
  int            n_requests = 0;
  int            n_checked = 0;
  int            n_configs = 0;
  int            cycle_count = 0;

  // predicted queue state
  logic [7:0] q_bytes [0:crq_pkg::DEF_DEPTH-1];
  logic       q_quotes[0:crq_pkg::DEF_DEPTH-1];
  int         q_head, q_tail, q_count, q_size;

  char_ring_queue_with_quote_bits_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .quote_in    (quote_in),
    .flush_count (flush_count),
    .match_mask  (match_mask),
    .match_quote (match_quote),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .status      (status),
    .byte_out    (byte_out),
    .quote_out   (quote_out),
    .run_count   (run_count),
    .fill_level  (fill_level)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [crq_pkg::CNT_W-1:0] got,
                             input logic [crq_pkg::CNT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic int next_slot(input int idx);
    return (idx + 1 >= q_size) ? 0 : idx + 1;
  endfunction

  task automatic empty_queue();
    q_head = 0;
    q_tail = 0;
    q_count = 0;
  endtask

  task automatic set_queue_size(input logic [crq_pkg::CNT_W-1:0] v);
    q_size = (v == 0) ? 1 : ((v > crq_pkg::DEF_DEPTH) ? crq_pkg::DEF_DEPTH : int'(v));
    empty_queue();
  endtask

  task automatic apply_request(input queue_req_t rq, output queue_result_t r);
    int idx, left;
    r = '0;
    r.status = crq_pkg::ST_OK;
    case (rq.req)
      crq_pkg::REQ_PUT: begin
        if (q_count >= q_size) begin
          r.status = crq_pkg::ST_FULL;
        end else begin
          q_bytes[q_tail] = rq.data;
          q_quotes[q_tail] = rq.quote;
          q_tail = next_slot(q_tail);
          q_count++;
        end
      end
      crq_pkg::REQ_GET: begin
        if (q_count == 0) begin
          r.status = crq_pkg::ST_EMPTY;
        end else begin
          r.byte_val = q_bytes[q_head];
          r.quote_val = q_quotes[q_head];
          q_head = next_slot(q_head);
          q_count--;
          if (q_count == 0) empty_queue();
        end
      end
      crq_pkg::REQ_UNPUT: begin
        if (q_count == 0) begin
          r.status = crq_pkg::ST_EMPTY;
        end else begin
          q_tail = (q_tail == 0) ? q_size - 1 : q_tail - 1;
          r.byte_val = q_bytes[q_tail];
          r.quote_val = q_quotes[q_tail];
          q_count--;
          if (q_count == 0) empty_queue();
        end
      end
      crq_pkg::REQ_FLUSH: begin
        if (int'(rq.fcnt) >= q_count) begin
          empty_queue();
        end else begin
          q_head += int'(rq.fcnt);
          if (q_head >= q_size) q_head -= q_size;
          q_count -= int'(rq.fcnt);
        end
      end
      crq_pkg::REQ_SCAN: begin
        idx = q_head;
        left = q_count;
        while (left > 0 && idx < q_size) begin
          if ((q_bytes[idx] & rq.mask) != 0) break;
          if (rq.mquote && q_quotes[idx]) break;
          r.run++;
          left--;
          idx++;
        end
      end
      default: ;
    endcase
    r.fill = crq_pkg::CNT_W'(q_count);
  endtask

  always @(posedge clk) begin : monitor
    queue_req_t    rq;
    queue_result_t want, got;
    if (rst) begin
      taken <= 1'b0;
      q_size = crq_pkg::QSIZE_RESET > crq_pkg::DEF_DEPTH ?
               crq_pkg::DEF_DEPTH : crq_pkg::QSIZE_RESET;
      empty_queue();
    end else begin
      taken <= start && !busy;
      if (done) begin
        got = '{status, byte_out, quote_out, run_count, fill_level};
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("status", crq_pkg::CNT_W'(got.status), crq_pkg::CNT_W'(want.status));
          check_field("byte_out", crq_pkg::CNT_W'(got.byte_val),
                      crq_pkg::CNT_W'(want.byte_val));
          check_field("quote_out", crq_pkg::CNT_W'(got.quote_val),
                      crq_pkg::CNT_W'(want.quote_val));
          check_field("run_count", got.run, want.run);
          check_field("fill_level", got.fill, want.fill);
          n_checked++;
        end
      end
      if (cfg_we) set_queue_size(cfg_wdata);
      if (start && !busy) begin
        rq = '{req_type, data_byte, quote_in, flush_count, match_mask, match_quote};
        apply_request(rq, want);
        expected_results.push_back(want);
        n_requests++;
      end
    end
  end

  always @(negedge clk) begin : driver
    queue_req_t  rq;
    logic        show;
    logic [63:0] noise;
    if (rst) begin
      start <= 1'b0;
    end else begin
      show = start && !taken;
      if (taken && pending_q.size() != 0) void'(pending_q.pop_front());
      if (!show && pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) show = 1'b1;
      if (show) begin
        rq = pending_q[0];
      end else begin
        noise = {$urandom, $urandom};
        rq = noise[$bits(queue_req_t)-1:0];
      end
      start <= show;
      req_type <= rq.req;
      data_byte <= rq.data;
      quote_in <= rq.quote;
      flush_count <= rq.fcnt;
      match_mask <= rq.mask;
      match_quote <= rq.mquote;
    end
  end

  task automatic push_req(input logic [crq_pkg::REQ_W-1:0] req, input logic [7:0] data,
                          input logic quote, input int fcnt, input logic [7:0] mask,
                          input logic mquote);
    pending_q.push_back('{req, data, quote, fcnt[crq_pkg::CNT_W-1:0], mask, mquote});
  endtask

  // bursts that lean towards filling or draining, so the queue swings between
  // empty, full and wrapped
  task automatic queue_random(input int n, input int size_hint);
    queue_req_t rq;
    int         burst_left, pick, top;
    bit         filling;
    burst_left = 0;
    filling = 1'b1;
    top = (size_hint + 2 > crq_pkg::DEF_DEPTH) ? crq_pkg::DEF_DEPTH : size_hint + 2;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        filling = ($urandom_range(0, 2) != 0);
        burst_left = $urandom_range(5, 60);
      end
      burst_left--;
      rq.data = 8'($urandom_range(0, 255));
      rq.quote = ($urandom_range(0, 3) == 0);
      rq.mquote = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 4) rq.mask = '0;
      else if (pick < 7) rq.mask = 8'h01 << $urandom_range(0, 7);
      else rq.mask = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      if (pick < 7) rq.fcnt = crq_pkg::CNT_W'($urandom_range(0, 8));
      else if (pick < 9) rq.fcnt = crq_pkg::CNT_W'($urandom_range(0, top));
      else rq.fcnt = crq_pkg::CNT_W'($urandom_range(0, crq_pkg::DEF_DEPTH));
      pick = $urandom_range(0, 99);
      if (filling) begin
        if (pick < 60) rq.req = crq_pkg::REQ_PUT;
        else if (pick < 75) rq.req = crq_pkg::REQ_GET;
        else if (pick < 82) rq.req = crq_pkg::REQ_UNPUT;
        else if (pick < 87) rq.req = crq_pkg::REQ_FLUSH;
        else if (pick < 97) rq.req = crq_pkg::REQ_SCAN;
        else rq.req = crq_pkg::REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      end else begin
        if (pick < 20) rq.req = crq_pkg::REQ_PUT;
        else if (pick < 55) rq.req = crq_pkg::REQ_GET;
        else if (pick < 68) rq.req = crq_pkg::REQ_UNPUT;
        else if (pick < 76) rq.req = crq_pkg::REQ_FLUSH;
        else if (pick < 95) rq.req = crq_pkg::REQ_SCAN;
        else rq.req = crq_pkg::REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      end
      pending_q.push_back(rq);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_results.size() != 0 || busy || start)
      @(negedge clk);
  endtask

  task automatic write_size(input int v);
    @(negedge clk);
    cfg_wdata <= v[crq_pkg::CNT_W-1:0];
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_configs++;
  endtask

  task automatic random_phase(input int size_val, input int n, input int idle);
    write_size(size_val);
    idle_pct = idle;
    queue_random(n, size_val);
    wait_drained();
  endtask

  initial begin : watchdog
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : sequencer
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_pct = 26;

    // empty queue cases, then a short mixed run at the reset size
    push_req(crq_pkg::REQ_GET, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_UNPUT, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_FLUSH, 8'h00, 1'b0, 5, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_SCAN, 8'h00, 1'b0, 0, 8'hFF, 1'b1);
    push_req(REQ_SPARE_HI, 8'hFF, 1'b1, 1024, 8'hFF, 1'b1);
    push_req(crq_pkg::REQ_PUT, 8'hFF, 1'b1, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h80, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h01, 1'b1, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_SCAN, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_SCAN, 8'h00, 1'b0, 0, 8'h00, 1'b1);
    push_req(crq_pkg::REQ_SCAN, 8'h00, 1'b0, 0, 8'h80, 1'b0);
    push_req(crq_pkg::REQ_GET, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_SCAN, 8'h00, 1'b0, 0, 8'h00, 1'b1);
    push_req(crq_pkg::REQ_UNPUT, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_FLUSH, 8'h00, 1'b0, 1, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h7F, 1'b1, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_FLUSH, 8'h00, 1'b0, 1024, 8'h00, 1'b0);
    push_req(REQ_SPARE_LO, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    queue_random(150, crq_pkg::DEF_DEPTH);
    wait_drained();

    // small queue size: full, tail wrap, unput across the wrap
    write_size(3);
    push_req(crq_pkg::REQ_PUT, 8'h11, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h22, 1'b1, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h33, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h44, 1'b1, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_GET, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_PUT, 8'h55, 1'b1, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_SCAN, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_UNPUT, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    push_req(crq_pkg::REQ_UNPUT, 8'h00, 1'b0, 0, 8'h00, 1'b0);
    queue_random(200, 3);
    wait_drained();

    random_phase(1, 120, 26);
    random_phase(2047, 300, 49);
    random_phase(0, 80, 49);
    random_phase(2, 150, 49);
    random_phase($urandom_range(4, 64), 300, 0);
    random_phase(crq_pkg::DEF_DEPTH, 200, 0);
    random_phase($urandom_range(5, crq_pkg::DEF_DEPTH - 1), 250, 0);

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("%0d requests over %0d queue size writes, %0d results compared, %0d mismatches",
             n_requests, n_configs, n_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
